[src/sfl_pkg.sv]
`default_nettype none
package sfl_pkg;

	localparam int CHANNELS      = 4;
	localparam int SAMPLE_BITS   = 16;
	localparam int FRACTION_BITS = 10;
	localparam int SUM_BITS      = 32;
	localparam int COUNT_BITS    = 16;
	localparam int LEVEL_BITS    = SUM_BITS - COUNT_BITS;
	localparam int MODE_BITS     = 2;
	localparam int KEEP_BITS     = 11;
	localparam int GAIN_BITS     = 16;
	localparam int MUL_A_BITS    = SUM_BITS;
	localparam int MUL_B_BITS    = GAIN_BITS;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [MODE_BITS-1:0] MODE_LATEST  = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_AVERAGE = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_LOWPASS = 2'd2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_FILTER_MODE   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEEP_COEF     = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_COEF     = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LOWPASS_SCALE = 2'd3;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	localparam logic [MODE_BITS-1:0]   RST_FILTER_MODE   = MODE_LOWPASS;
	localparam logic [KEEP_BITS-1:0]   RST_KEEP_COEF     = 11'd1018;
	localparam logic [GAIN_BITS-1:0]   RST_GAIN_COEF     = 16'd192;
	localparam logic [COUNT_BITS-1:0]  RST_LOWPASS_SCALE = 16'd32;

	typedef struct packed {
		logic                   kind;
		logic [SAMPLE_BITS-1:0] sample_ch0;
		logic [SAMPLE_BITS-1:0] sample_ch1;
		logic [SAMPLE_BITS-1:0] sample_ch2;
		logic [SAMPLE_BITS-1:0] sample_ch3;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] level_ch0;
		logic [LEVEL_BITS-1:0] level_ch1;
		logic [LEVEL_BITS-1:0] level_ch2;
		logic [LEVEL_BITS-1:0] level_ch3;
		logic                  count_zero;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage
`default_nettype wire

[src/sfl_mul.sv]
`default_nettype none
module sfl_mul #(
	parameter int A_BITS = sfl_pkg::MUL_A_BITS,
	parameter int B_BITS = sfl_pkg::MUL_B_BITS
) (
	input  wire logic                     clk,
	input  wire logic [A_BITS-1:0]        a,
	input  wire logic [B_BITS-1:0]        b,
	output logic      [A_BITS+B_BITS-1:0] prod
);

	logic [A_BITS+B_BITS-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= {{B_BITS{1'b0}}, a} * {{A_BITS{1'b0}}, b};
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

[src/sfl_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle. A quotient that cannot fit
// (high half of dividend >= divisor) saturates without iterating.
module sfl_div #(
	parameter int N_BITS = sfl_pkg::SUM_BITS,
	parameter int D_BITS = sfl_pkg::COUNT_BITS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [N_BITS-1:0]          dividend,
	input  wire logic [D_BITS-1:0]          divisor,
	output logic      [N_BITS-D_BITS-1:0]   quotient,
	output sfl_pkg::div_status_t            status
);

	localparam int Q_BITS   = N_BITS - D_BITS;
	localparam int CNT_BITS = (Q_BITS > 1) ? $clog2(Q_BITS) : 1;

	logic [D_BITS-1:0]   rem_q;
	logic [Q_BITS-1:0]   quo_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [D_BITS-1:0] hi;
	logic [D_BITS:0]   trial;
	logic [D_BITS:0]   diff;
	logic              trial_ge;
	logic              sat;

	assign hi       = dividend[N_BITS-1 -: D_BITS];
	assign sat      = (hi >= divisor);
	assign trial    = {rem_q, quo_q[Q_BITS-1]};
	assign trial_ge = (trial >= {1'b0, divisor});
	assign diff     = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !sat;
			done_q <= sat;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_BITS'(Q_BITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= hi;
			quo_q <= sat ? '1 : dividend[Q_BITS-1:0];
		end else if (busy_q) begin
			rem_q <= trial_ge ? diff[D_BITS-1:0] : trial[D_BITS-1:0];
			quo_q <= {quo_q[Q_BITS-2:0], trial_ge};
		end
	end

	assign quotient = quo_q;
	assign status   = {busy_q, done_q};

endmodule
`default_nettype wire

[src/four_channel_strain_filter.sv]
`default_nettype none
// Four-channel strain conditioner. A sample request updates per-channel sums
// as latest value, running average or first-order lowpass
// sum = (keep*sum + gain*sample) >> FRACTION_BITS, saturated to 32 bits; a read
// request returns sum/count per channel, saturated to 16 bits, with count_zero
// set and levels zero when the count is zero. Average mode clears sums and
// count on every read. Latest and average samples update the sums as they are
// accepted; a lowpass sample steps through LP_A, LP_B and LP_C per channel on
// one shared 32x16 multiplier. A read runs the serial divider, one quotient bit
// per cycle, once per channel; a saturating channel skips the iteration, and a
// read with zero count skips the divider. The input is not ready while a
// request is in work; a finished result sits in an output register, so the
// next request is taken while it waits.
module four_channel_strain_filter #(
	parameter int FRACTION_BITS = sfl_pkg::FRACTION_BITS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire sfl_pkg::in_item_t                    in_item,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output sfl_pkg::out_item_t                        out_item,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [sfl_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [sfl_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	localparam int NCH      = sfl_pkg::CHANNELS;
	localparam int CH_BITS  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int SB       = sfl_pkg::SAMPLE_BITS;
	localparam int SUMB     = sfl_pkg::SUM_BITS;
	localparam int CNTB     = sfl_pkg::COUNT_BITS;
	localparam int LVLB     = sfl_pkg::LEVEL_BITS;
	localparam int MA       = sfl_pkg::MUL_A_BITS;
	localparam int MB       = sfl_pkg::MUL_B_BITS;
	localparam int PB       = MA + MB;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_LP_A     = 3'd1;
	localparam logic [2:0] S_LP_B     = 3'd2;
	localparam logic [2:0] S_LP_C     = 3'd3;
	localparam logic [2:0] S_DIV_GO   = 3'd4;
	localparam logic [2:0] S_DIV_WAIT = 3'd5;
	localparam logic [2:0] S_OUT      = 3'd6;

	logic [2:0] state_q;

	logic [sfl_pkg::MODE_BITS-1:0] mode_q;
	logic [sfl_pkg::KEEP_BITS-1:0] keep_q;
	logic [sfl_pkg::GAIN_BITS-1:0] gain_q;
	logic [CNTB-1:0]               scale_q;

	logic [SUMB-1:0] sum_q  [NCH];
	logic [CNTB-1:0] count_q;
	logic [SB-1:0]   samp_q [NCH];
	logic [LVLB-1:0] lvl_q  [NCH];
	logic            zero_q;
	logic [CH_BITS-1:0] ch_q;
	logic [PB-1:0]   acc_q;

	logic                out_valid_q;
	sfl_pkg::out_item_t  out_q;

	logic [SB-1:0] in_samp [NCH];
	logic          in_acc;
	logic          is_sample;
	logic          is_read;
	logic          ch_last;
	logic          out_free;

	logic [MA-1:0] mul_a;
	logic [MB-1:0] mul_b;
	logic [PB-1:0] prod;
	logic [PB:0]   lp_total;
	logic [PB:0]   lp_shift;
	logic [SUMB-1:0] lp_new;

	logic                  div_start;
	logic [LVLB-1:0]       div_quo;
	sfl_pkg::div_status_t  div_st;

	assign in_samp[0] = in_item.sample_ch0;
	assign in_samp[1] = in_item.sample_ch1;
	assign in_samp[2] = in_item.sample_ch2;
	assign in_samp[3] = in_item.sample_ch3;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign is_sample = in_acc && (in_item.kind == sfl_pkg::KIND_SAMPLE);
	assign is_read   = in_acc && (in_item.kind == sfl_pkg::KIND_READ);
	assign ch_last   = (ch_q == CH_BITS'(NCH - 1));
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= sfl_pkg::RST_FILTER_MODE;
			keep_q  <= sfl_pkg::RST_KEEP_COEF;
			gain_q  <= sfl_pkg::RST_GAIN_COEF;
			scale_q <= sfl_pkg::RST_LOWPASS_SCALE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sfl_pkg::REG_FILTER_MODE:   mode_q  <= cfg_data[sfl_pkg::MODE_BITS-1:0];
				sfl_pkg::REG_KEEP_COEF:     keep_q  <= cfg_data[sfl_pkg::KEEP_BITS-1:0];
				sfl_pkg::REG_GAIN_COEF:     gain_q  <= cfg_data[sfl_pkg::GAIN_BITS-1:0];
				sfl_pkg::REG_LOWPASS_SCALE: scale_q <= cfg_data[CNTB-1:0];
				default: ;
			endcase
		end
	end

	// shared multiplier: keep*sum, then gain*sample
	assign mul_a = (state_q == S_LP_A) ? sum_q[ch_q] : MA'(samp_q[ch_q]);
	assign mul_b = (state_q == S_LP_A) ? MB'(keep_q) : gain_q;

	sfl_mul #(
		.A_BITS(MA),
		.B_BITS(MB)
	) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign lp_total = {1'b0, acc_q} + {1'b0, prod};
	assign lp_shift = lp_total >> FRACTION_BITS;
	assign lp_new   = (|lp_shift[PB:SUMB]) ? '1 : lp_shift[SUMB-1:0];

	assign div_start = (state_q == S_DIV_GO);

	sfl_div #(
		.N_BITS(SUMB),
		.D_BITS(CNTB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[ch_q]),
		.divisor  (count_q),
		.quotient (div_quo),
		.status   (div_st)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					ch_q <= '0;
					if (is_sample && mode_q == sfl_pkg::MODE_LOWPASS) begin
						state_q <= S_LP_A;
					end else if (is_read) begin
						state_q <= (count_q == '0) ? S_OUT : S_DIV_GO;
					end
				end
				S_LP_A: state_q <= S_LP_B;
				S_LP_B: state_q <= S_LP_C;
				S_LP_C: begin
					ch_q    <= ch_q + 1'b1;
					state_q <= ch_last ? S_IDLE : S_LP_A;
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_st.done) begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ch_last ? S_OUT : S_DIV_GO;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				sum_q[i] <= '0;
			end
			count_q <= '0;
		end else if (is_sample) begin
			if (mode_q == sfl_pkg::MODE_LATEST) begin
				for (int i = 0; i < NCH; i++) begin
					sum_q[i] <= SUMB'(in_samp[i]);
				end
				count_q <= CNTB'(1);
			end else if (mode_q == sfl_pkg::MODE_AVERAGE) begin
				for (int i = 0; i < NCH; i++) begin
					logic [SUMB:0] t;
					t = {1'b0, sum_q[i]} + (SUMB+1)'(in_samp[i]);
					sum_q[i] <= t[SUMB] ? '1 : t[SUMB-1:0];
				end
				if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
			end
		end else if (state_q == S_LP_C) begin
			sum_q[ch_q] <= lp_new;
			if (ch_last) begin
				count_q <= scale_q;
			end
		end else if (state_q == S_OUT && out_free && mode_q == sfl_pkg::MODE_AVERAGE) begin
			for (int i = 0; i < NCH; i++) begin
				sum_q[i] <= '0;
			end
			count_q <= '0;
		end
	end

	// datapath holding registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < NCH; i++) begin
				samp_q[i] <= in_samp[i];
				lvl_q[i]  <= '0;
			end
			zero_q <= (count_q == '0);
		end
		if (state_q == S_LP_B) begin
			acc_q <= prod;
		end
		if (state_q == S_DIV_WAIT && div_st.done) begin
			lvl_q[ch_q] <= div_quo;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_q.level_ch0  <= lvl_q[0];
			out_q.level_ch1  <= lvl_q[1];
			out_q.level_ch2  <= lvl_q[2];
			out_q.level_ch3  <= lvl_q[3];
			out_q.count_zero <= zero_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef NO_ASSERTIONS
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_st.busy)
		else $error("divider busy while input ready");

	a_zero_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.count_zero) |->
		(out_item.level_ch0 == '0 && out_item.level_ch1 == '0 &&
		 out_item.level_ch2 == '0 && out_item.level_ch3 == '0))
		else $error("nonzero level with zero count");

	a_latest_count: assert property (@(posedge clk) disable iff (!arst_n)
		(is_sample && mode_q == sfl_pkg::MODE_LATEST) |=> (count_q == CNTB'(1)))
		else $error("latest sample did not set count to one");
`endif

endmodule
`default_nettype wire
